// ----- design/vector_difference_normalize_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the vector difference normalizer
// Shared helper macros so that checks read the same way across the design.
// ----------------------------------------------------------------------------
`ifndef VECTOR_DIFFERENCE_NORMALIZE_MACROS_SVH
`define VECTOR_DIFFERENCE_NORMALIZE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VDN_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("vdn same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define VDN_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("vdn next-cycle check failed");

`endif

// ----- design/vdn_pkg.sv -----
// ----------------------------------------------------------------------------
// vdn_pkg
// Types and constants shared by the vector difference normalizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vdn_pkg;

    // Number of square root digit steps; the unit steps use the low ones.
    localparam int unsigned SqrtSteps = 18;
    localparam int unsigned UnitTopBit = 14;

    // State carried down the digit pipeline for one beat.
    typedef struct packed {
        logic               zero;
        logic               neg_x;
        logic               neg_y;
        logic [33:0]        s;
        logic [17:0]        r;
        logic [33:0]        rem;
        logic [14:0]        q_x;
        logic [14:0]        q_y;
        logic signed [67:0] e_x;
        logic signed [67:0] e_y;
        logic signed [50:0] p_x;
        logic signed [50:0] p_y;
    } iter_t;

endpackage

`default_nettype wire

// ----- design/vector_difference_normalize.sv -----
// ----------------------------------------------------------------------------
// vector_difference_normalize
// Length and rounded unit direction (or perpendicular) of a minus b.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one point pair per beat: a_x, a_y, b_x, b_y in
//   signed Q8.8 on s_tdata, and the operation select on s_tuser (0 gives the
//   unit direction of a - b, 1 the unit perpendicular (dy, -dx)).
//   The output channel returns one beat per input beat, in order: unit_x and
//   unit_y in signed Q1.14, length in unsigned Q9.8 rounded down, and the
//   zero_length flag on m_tuser. A zero difference gives zero components,
//   zero length and the flag set.
//   An accepted input beat passes three front stages, eighteen square root
//   digit stages (the low fifteen also resolve the unit digits) and the
//   output register. Throughput is one beat per cycle unless the receiver
//   stalls; the digit pipeline sets the depth.
//   Reset clears all valid bits; the pipeline then holds no beats.
//   When the receiver stalls, the whole pipeline holds and s_tready drops
//   once the output register is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_difference_normalize (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // a_x, a_y, b_x, b_y (16 bits each)
    input  wire logic [0:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // unit_x, unit_y, length (25), zero pad
    output logic [0:0]       m_tuser    // zero_length
);
    import vdn_pkg::*;

    `include "vector_difference_normalize_macros.svh"

    logic        en;
    logic        v_chain [SqrtSteps + 1];
    iter_t       it_chain [SqrtSteps + 1];
    iter_t       last;
    logic        m_tvalid_reg;
    logic [15:0] ux_reg;
    logic [15:0] uy_reg;
    logic [24:0] len_reg;
    logic        zero_reg;

    // The pipeline advances whenever the output register can take a beat.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    vdn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .operation (s_tuser[0]),
        .a_x       (s_tdata[15:0]),
        .a_y       (s_tdata[31:16]),
        .b_x       (s_tdata[47:32]),
        .b_y       (s_tdata[63:48]),
        .out_valid (v_chain[0]),
        .out_it    (it_chain[0])
    );

    // Digit stages, most significant digit first.
    for (genvar k = 0; k < SqrtSteps; k++)
    begin : g_step
        vdn_step #(
            .B (SqrtSteps - 1 - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_chain[k]),
            .in_it     (it_chain[k]),
            .out_valid (v_chain[k + 1]),
            .out_it    (it_chain[k + 1])
        );
    end

    assign last = it_chain[SqrtSteps];

    // Output register: apply signs and force the zero-vector result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= v_chain[SqrtSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= last.zero;
            if (last.zero)
            begin
                ux_reg  <= '0;
                uy_reg  <= '0;
                len_reg <= '0;
            end
            else
            begin
                ux_reg  <= last.neg_x ? (16'd0 - {1'b0, last.q_x}) : {1'b0, last.q_x};
                uy_reg  <= last.neg_y ? (16'd0 - {1'b0, last.q_y}) : {1'b0, last.q_y};
                len_reg <= {7'd0, last.r};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, len_reg, uy_reg, ux_reg};
    assign m_tuser  = zero_reg;

    // A flagged zero vector carries an all-zero payload.
    `VDN_ASSERT_IMPL(a_zero_payload, m_tvalid && m_tuser[0], m_tdata == 64'd0)
    // A nonzero difference always has a length of at least one raw unit.
    `VDN_ASSERT_IMPL(a_nonzero_len, m_tvalid && !m_tuser[0], m_tdata[56:32] != 25'd0)
    // A stalled result stays put, so the pipeline behind it must not move.
    `VDN_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

`default_nettype wire

// ----- design/vdn_front.sv -----
// ----------------------------------------------------------------------------
// vdn_front
// Three pipeline stages: difference and magnitude, squares, and the setup
// of the square root and unit digit recurrences.
// ----------------------------------------------------------------------------
`default_nettype none

module vdn_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic                 operation,
    input  wire logic [15:0]          a_x,
    input  wire logic [15:0]          a_y,
    input  wire logic [15:0]          b_x,
    input  wire logic [15:0]          b_y,
    output logic                      out_valid,
    output vdn_pkg::iter_t            out_it
);
    import vdn_pkg::*;

    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] adx;
    logic [16:0] ady;

    logic        v1_reg;
    logic [16:0] cx_reg;
    logic [16:0] cy_reg;
    logic        nx1_reg;
    logic        ny1_reg;

    logic        v2_reg;
    logic [33:0] sx_reg;
    logic [33:0] sy_reg;
    logic        nx2_reg;
    logic        ny2_reg;

    logic        v3_reg;
    iter_t       it_reg;
    iter_t       it_next;
    logic [33:0] s_sum;

    // Exact 17-bit differences and their magnitudes.
    assign dx  = {a_x[15], a_x} - {b_x[15], b_x};
    assign dy  = {a_y[15], a_y} - {b_y[15], b_y};
    assign adx = dx[16] ? (17'd0 - dx) : dx;
    assign ady = dy[16] ? (17'd0 - dy) : dy;

    // Stage one: choose the numerator components for the operation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg  <= operation ? ady : adx;
            cy_reg  <= operation ? adx : ady;
            nx1_reg <= operation ? dy[16] : dx[16];
            ny1_reg <= operation ? ~dx[16] : dy[16];
        end
    end

    // Stage two: squares of both numerator magnitudes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg  <= cx_reg * cx_reg;
            sy_reg  <= cy_reg * cy_reg;
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
        end
    end

    // Stage three: squared length and the starting remainders.
    assign s_sum = sx_reg + sy_reg;

    always_comb
    begin
        it_next.zero  = (s_sum == 34'd0);
        it_next.neg_x = nx2_reg;
        it_next.neg_y = ny2_reg;
        it_next.s     = s_sum;
        it_next.r     = '0;
        it_next.rem   = s_sum;
        it_next.q_x   = '0;
        it_next.q_y   = '0;
        it_next.e_x   = $signed({4'd0, sx_reg, 30'd0}) - $signed({34'd0, s_sum});
        it_next.e_y   = $signed({4'd0, sy_reg, 30'd0}) - $signed({34'd0, s_sum});
        it_next.p_x   = $signed(51'd0) - $signed({17'd0, s_sum});
        it_next.p_y   = $signed(51'd0) - $signed({17'd0, s_sum});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg <= it_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_it    = it_reg;

endmodule

`default_nettype wire

// ----- design/vdn_step.sv -----
// ----------------------------------------------------------------------------
// vdn_step
// One registered digit step: a square root digit and, for the low digits,
// one rounded unit-component digit for each of x and y.
// ----------------------------------------------------------------------------
`default_nettype none

module vdn_step #(
    parameter int unsigned B = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  vdn_pkg::iter_t      in_it,
    output logic                out_valid,
    output vdn_pkg::iter_t      out_it
);
    import vdn_pkg::*;

    logic               v_reg;
    iter_t              it_reg;
    iter_t              it_next;
    logic [36:0]        sub_r;
    logic [36:0]        rem_w;
    logic signed [67:0] s_w;
    logic signed [67:0] tt_x;
    logic signed [67:0] tt_y;
    logic signed [67:0] ex_try;
    logic signed [67:0] ey_try;
    logic signed [67:0] p_inc;

    // Square root digit: try setting bit B of the root.
    assign sub_r = (37'(in_it.r) << (B + 1)) + (37'd1 << (2 * B));
    assign rem_w = {3'd0, in_it.rem};

    // Unit digit: trial (2c-1)^2 * s against c^2 * 2^30 kept as a remainder.
    assign s_w    = $signed({34'd0, in_it.s});
    assign tt_x   = (68'(in_it.p_x) + (s_w <<< B)) <<< (B + 2);
    assign tt_y   = (68'(in_it.p_y) + (s_w <<< B)) <<< (B + 2);
    assign ex_try = in_it.e_x - tt_x;
    assign ey_try = in_it.e_y - tt_y;
    assign p_inc  = s_w <<< (B + 1);

    always_comb
    begin
        it_next = in_it;
        if (rem_w >= sub_r)
        begin
            it_next.rem = 34'(rem_w - sub_r);
            it_next.r   = in_it.r | (18'd1 << B);
        end
        if (B <= UnitTopBit)
        begin
            if (!ex_try[67])
            begin
                it_next.e_x = ex_try;
                it_next.q_x = in_it.q_x | 15'(18'd1 << B);
                it_next.p_x = 51'(68'(in_it.p_x) + p_inc);
            end
            if (!ey_try[67])
            begin
                it_next.e_y = ey_try;
                it_next.q_y = in_it.q_y | 15'(18'd1 << B);
                it_next.p_y = 51'(68'(in_it.p_y) + p_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg <= it_next;
        end
    end

    assign out_valid = v_reg;
    assign out_it    = it_reg;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for vector_difference_normalize
// Drives point pairs through the stream input, predicts the length and the
// rounded unit direction or perpendicular, and compares every output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [15:0] unit_x;
        logic [15:0] unit_y;
        logic [24:0] length;
        logic        zero_length;
    } vec_result_t;

    typedef struct {
        logic        op;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] bx;
        logic [15:0] by;
        logic        known;
        vec_result_t res;
    } stim_row_t;

    localparam logic OpDirection = 1'b0;
    localparam logic OpPerpendicular = 1'b1;
    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 40;
    localparam int RandomItems = 1400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    vec_result_t pending_results[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    vector_difference_normalize dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Floor square root, bit by bit.
    function automatic longint unsigned floor_sqrt(input longint unsigned s);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 17; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= s)
                r = c;
        end
        return r;
    endfunction

    // Rounded |c| * 2^14 / sqrt(s), with the sign applied.
    function automatic logic [15:0] unit_component(input longint c, input longint unsigned s);
        longint unsigned cabs;
        longint unsigned t;
        longint unsigned q;
        longint unsigned trial;
        longint unsigned odd;
        cabs = (c < 0) ? longint'(-c) : longint'(c);
        t = (cabs * cabs) << 30;
        q = 0;
        for (int b = 14; b >= 0; b--)
        begin
            trial = q | (64'd1 << b);
            odd = 2 * trial - 1;
            if (odd * odd * s <= t)
                q = trial;
        end
        return (c < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic vec_result_t predict_unit_vector(input logic op,
                                                        input logic [15:0] ax,
                                                        input logic [15:0] ay,
                                                        input logic [15:0] bx,
                                                        input logic [15:0] by);
        vec_result_t     r;
        longint          dx;
        longint          dy;
        longint unsigned s;
        dx = longint'($signed(ax)) - longint'($signed(bx));
        dy = longint'($signed(ay)) - longint'($signed(by));
        s = dx * dx + dy * dy;
        r.zero_length = (s == 0);
        r.length = 25'(floor_sqrt(s));
        if (s == 0)
        begin
            r.unit_x = '0;
            r.unit_y = '0;
        end
        else if (op == OpDirection)
        begin
            r.unit_x = unit_component(dx, s);
            r.unit_y = unit_component(dy, s);
        end
        else
        begin
            r.unit_x = unit_component(dy, s);
            r.unit_y = unit_component(-dx, s);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Send one beat, queueing its expected result on acceptance.
    // The valid line stays high after acceptance unless the sender idles.
    task automatic send_pair(input logic op, input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] bx, input logic [15:0] by,
                             input logic known, input vec_result_t typed);
        vec_result_t exp_res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {by, bx, ay, ax};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        exp_res = predict_unit_vector(op, ax, ay, bx, by);
        if (known && exp_res != typed)
            report_mismatch("table entry vs predictor", 0, 1);
        pending_results.push_back(known ? typed : exp_res);
    endtask

    // Output side: random stall and beat checking.
    always @(posedge clk)
    begin
        vec_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected beat", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[15:0] !== want.unit_x)
                        report_mismatch("unit_x", $signed(m_tdata[15:0]), $signed(want.unit_x));
                    if (m_tdata[31:16] !== want.unit_y)
                        report_mismatch("unit_y", $signed(m_tdata[31:16]), $signed(want.unit_y));
                    if (m_tdata[56:32] !== want.length)
                        report_mismatch("length", m_tdata[56:32], want.length);
                    if (m_tuser[0] !== want.zero_length)
                        report_mismatch("zero_length", m_tuser[0], want.zero_length);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(64)) - 32);
            2: return $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(3))
                                         : 16'h8000 + 16'($urandom_range(3));
            default: return 16'($signed($urandom_range(2048)) - 1024);
        endcase
    endfunction

    initial
    begin
        stim_row_t   table_rows[$];
        stim_row_t   row;
        vec_result_t zr;
        logic [15:0] ax;
        logic [15:0] ay;
        zr = '{16'd0, 16'd0, 25'd0, 1'b1};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: zero vectors, axes, extremes, both operations.
        table_rows.push_back('{OpDirection, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, zr});
        table_rows.push_back('{OpPerpendicular, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1, zr});
        table_rows.push_back('{OpDirection, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 1,
                               '{16'd16384, 16'd0, 25'd256, 1'b0}});
        table_rows.push_back('{OpPerpendicular, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 1,
                               '{16'd0, 16'hC000, 25'd256, 1'b0}});
        table_rows.push_back('{OpDirection, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1,
                               '{16'd0, 16'd16384, 25'd1, 1'b0}});
        table_rows.push_back('{OpDirection, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 0, zr});
        table_rows.push_back('{OpPerpendicular, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 0, zr});
        table_rows.push_back('{OpDirection, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 0, zr});
        table_rows.push_back('{OpPerpendicular, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 0, zr});
        table_rows.push_back('{OpDirection, 16'h0003, 16'h0004, 16'h0000, 16'h0000, 1,
                               '{16'd9830, 16'd13107, 25'd5, 1'b0}});
        table_rows.push_back('{OpPerpendicular, 16'hFFFD, 16'hFFFC, 16'h0000, 16'h0000, 0, zr});
        table_rows.push_back('{OpDirection, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 0, zr});
        table_rows.push_back('{OpDirection, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 0, zr});
        table_rows.push_back('{OpPerpendicular, 16'h0000, 16'h8000, 16'h0000, 16'h7FFF, 0, zr});
        table_rows.push_back('{OpDirection, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, zr});
        table_rows.push_back('{OpDirection, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 0, zr});
        foreach (table_rows[i])
        begin
            row = table_rows[i];
            send_pair(row.op, row.ax, row.ay, row.bx, row.by, row.known, row.res);
        end

        // Random part in idling phases.
        for (int n = 0; n < RandomItems; n++)
        begin
            case (n / 280)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                3: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // Hold off once until the pipeline has fully drained.
            if (n == 700)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            ax = rand_coord();
            ay = rand_coord();
            if ($urandom_range(19) == 0)
                send_pair(1'($urandom), ax, ay, ax, ay, 0, zr);
            else
                send_pair(1'($urandom), ax, ay, rand_coord(), rand_coord(), 0, zr);
        end

        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/vdn_pkg.sv
design/vdn_front.sv
design/vdn_step.sv
design/vector_difference_normalize.sv
verif/tb.sv
